### rtl/core/pcs_pkg.sv
// Package for the prime count sieve: field widths and payload types.
// No dependencies; imported by the channel interfaces and the top level.
package pcs_pkg;

    localparam int LIMIT_W = 16;
    localparam int COUNT_W = 17;

    typedef logic [LIMIT_W-1:0] t_limit;
    typedef logic [COUNT_W-1:0] t_count;

endpackage

### rtl/core/pcs_if.sv
// Valid/ready channel interfaces for the prime count sieve.
// Depends on pcs_pkg for the payload types.
interface pcs_limit_if import pcs_pkg::*; ();
    logic   valid;
    logic   ready;
    t_limit limit;

    modport source (output valid, output limit, input ready);
    modport sink   (input valid, input limit, output ready);
endinterface

interface pcs_count_if import pcs_pkg::*; ();
    logic   valid;
    logic   ready;
    t_count prime_count;

    modport source (output valid, output prime_count, input ready);
    modport sink   (input valid, input prime_count, output ready);
endinterface

### rtl/core/pcs_mark_ram.sv
// One-bit composite mark store: one write port and one read port with a
// registered read. No dependencies.
module pcs_mark_ram #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic              i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic              o_rdata
);

    logic r_mem [DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/prime_count_sieve.sv
// Prime count sieve: one result item per limit item, the number of primes in 2..limit.
// For limit L >= 2 the item clears the marks for 2..L, then for each base i with i*i <= L marks
// the multiples of i from i*i up to L if i is unmarked, and then counts the unmarked entries in 2..L.
// A limit below two goes straight to the done state and gives a zero result.
// One item at a time; the single mark memory port pair can do one write and one read per cycle.
// Reset clears the control state; marks are not reset; each item of limit >= 2 clears them first.
module prime_count_sieve import pcs_pkg::*; #(
    parameter int SIEVE_DEPTH = 65536
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pcs_limit_if.sink     i_limit,
    pcs_count_if.source   o_count
);

    localparam int ADDR_W = (SIEVE_DEPTH > 1) ? $clog2(SIEVE_DEPTH) : 1;
    localparam int PTR_W  = ADDR_W + 2;
    localparam logic [31:0] MAX_LIM = 32'(SIEVE_DEPTH - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_ITEST = 3'd2;
    localparam logic [2:0] S_ICHK  = 3'd3;
    localparam logic [2:0] S_MARK  = 3'd4;
    localparam logic [2:0] S_COUNT = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]        r_state;
    logic [PTR_W-1:0]  r_lim;
    logic [PTR_W-1:0]  r_ptr;
    logic [ADDR_W-1:0] r_i;
    logic [PTR_W-1:0]  r_sq;
    logic              r_pend;
    t_count            r_cnt;
    logic              r_out_vld;
    t_count            r_out_cnt;

    logic [31:0]       lim_ext;
    logic [31:0]       lim_sat;
    logic [PTR_W-1:0]  n_mark_ptr;
    logic [PTR_W-1:0]  n_sq;
    logic              cnt_issue;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic              ram_rdata;

    assign lim_ext    = {16'b0, i_limit.limit};
    assign lim_sat    = (lim_ext > MAX_LIM) ? MAX_LIM : lim_ext;
    assign n_mark_ptr = r_ptr + PTR_W'(r_i);
    // (i+1)^2 = i^2 + 2i + 1
    assign n_sq       = r_sq + PTR_W'({r_i, 1'b1});
    assign cnt_issue  = (r_ptr <= r_lim);

    assign i_limit.ready       = (r_state == S_IDLE);
    assign o_count.valid       = r_out_vld;
    assign o_count.prime_count = r_out_cnt;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_ptr[ADDR_W-1:0];
        ram_wdata = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = r_ptr[ADDR_W-1:0];
        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_ITEST: begin
                ram_re    = (r_sq <= r_lim);
                ram_raddr = r_i;
            end
            S_MARK: begin
                ram_we    = 1'b1;
                ram_wdata = 1'b1;
            end
            S_COUNT: begin
                ram_re = cnt_issue;
            end
            default: begin
            end
        endcase
    end

    pcs_mark_ram #(
        .DEPTH  (SIEVE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_marks (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            // The done state sets the result valid itself, so it is not cleared there.
            if (r_out_vld && o_count.ready && r_state != S_DONE) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_limit.valid) begin
                        r_lim <= lim_sat[PTR_W-1:0];
                        r_ptr <= PTR_W'(2);
                        r_cnt <= '0;
                        if (lim_sat < 32'd2) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_CLEAR;
                        end
                    end
                end
                S_CLEAR: begin
                    if (r_ptr == r_lim) begin
                        r_i     <= ADDR_W'(2);
                        r_sq    <= PTR_W'(4);
                        r_state <= S_ITEST;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                S_ITEST: begin
                    if (r_sq > r_lim) begin
                        r_ptr   <= PTR_W'(2);
                        r_pend  <= 1'b0;
                        r_state <= S_COUNT;
                    end else begin
                        r_state <= S_ICHK;
                    end
                end
                S_ICHK: begin
                    if (!ram_rdata) begin
                        r_ptr   <= r_sq;
                        r_state <= S_MARK;
                    end else begin
                        r_sq    <= n_sq;
                        r_i     <= r_i + 1'b1;
                        r_state <= S_ITEST;
                    end
                end
                S_MARK: begin
                    if (n_mark_ptr > r_lim) begin
                        r_sq    <= n_sq;
                        r_i     <= r_i + 1'b1;
                        r_state <= S_ITEST;
                    end else begin
                        r_ptr <= n_mark_ptr;
                    end
                end
                S_COUNT: begin
                    // Read data arrives in the cycle after the address; r_pend tracks it.
                    if (cnt_issue) begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                    r_pend <= cnt_issue;
                    if (r_pend && !ram_rdata) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (!cnt_issue && !r_pend) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_vld || o_count.ready) begin
                        r_out_vld <= 1'b1;
                        r_out_cnt <= r_cnt;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_mark_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK) |-> (r_ptr <= r_lim && r_ptr >= r_sq))
        else $error("mark write outside the sieve range");

    a_square_tracks_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK || r_state == S_ICHK) |->
        (32'(r_sq) == 32'(r_i) * 32'(r_i)))
        else $error("running square does not match the sieve base");

    a_no_write_in_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COUNT) |-> !ram_we)
        else $error("mark store written while counting");

    a_small_limit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_limit.valid && i_limit.ready && i_limit.limit < 16'd2) |=>
        (r_state == S_DONE && r_cnt == '0))
        else $error("limit below two does not give a zero count");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == S_DONE))
        else $error("result item raised outside the done state");

endmodule
